### rtl/core/hsv_pixel_color_classifier_core_assert.svh
// ----------------------------------------------------------------------------
// hsv pixel colour classifier assertion macros
// shared property forms used by the classifier core
// ----------------------------------------------------------------------------
`ifndef HSV_PIXEL_COLOR_CLASSIFIER_CORE_ASSERT_SVH
`define HSV_PIXEL_COLOR_CLASSIFIER_CORE_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define HSVC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define HSVC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/hsvc_pkg.sv
// ----------------------------------------------------------------------------
// hsvc_pkg
// types, register indexes, reset values and class codes of the classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsvc_pkg;

	// field widths
	localparam int unsigned PIX_W     = 8;
	localparam int unsigned CLASS_W   = 4;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 64;
	localparam int unsigned MAX_HUE_ENTRIES = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLACK_VALUE_MAX = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WHITE_VALUE_MIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WHITE_SAT_MAX   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GREY_SAT_MAX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GREY_VALUE_MAX  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HUE_BOUNDS      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HUE_ENABLES     = 3'd6;

	// threshold reset values
	localparam logic [PIX_W-1:0] RST_BLACK_VALUE_MAX = 8'd75;
	localparam logic [PIX_W-1:0] RST_WHITE_VALUE_MIN = 8'd190;
	localparam logic [PIX_W-1:0] RST_WHITE_SAT_MAX   = 8'd27;
	localparam logic [PIX_W-1:0] RST_GREY_SAT_MAX    = 8'd53;
	localparam logic [PIX_W-1:0] RST_GREY_VALUE_MAX  = 8'd185;

	// class codes
	localparam logic [CLASS_W-1:0] CLASS_BLACK    = 4'd0;
	localparam logic [CLASS_W-1:0] CLASS_WHITE    = 4'd1;
	localparam logic [CLASS_W-1:0] CLASS_GREY     = 4'd2;
	localparam logic [CLASS_W-1:0] CLASS_HUE_BASE = 4'd3;

	typedef struct packed {
		logic [PIX_W-1:0] hue;
		logic [PIX_W-1:0] saturation;
		logic [PIX_W-1:0] brightness;
	} pixel_t;

	typedef struct packed {
		logic [CLASS_W-1:0] color_class;
		logic               not_found;
	} result_t;

	// achromatic thresholds
	typedef struct packed {
		logic [PIX_W-1:0] black_value_max;
		logic [PIX_W-1:0] white_value_min;
		logic [PIX_W-1:0] white_sat_max;
		logic [PIX_W-1:0] grey_sat_max;
		logic [PIX_W-1:0] grey_value_max;
	} thresholds_t;

endpackage

### rtl/core/hsvc_channels.sv
// ----------------------------------------------------------------------------
// hsvc channels
// valid/ready channel interfaces for pixels, results and register writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// pixel channel
interface hsvc_pix_if;
	logic                      valid;
	logic                      ready;
	logic [hsvc_pkg::PIX_W-1:0] hue;
	logic [hsvc_pkg::PIX_W-1:0] saturation;
	logic [hsvc_pkg::PIX_W-1:0] brightness;

	modport source (output valid, hue, saturation, brightness, input ready);
	modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

// result channel
interface hsvc_res_if;
	logic                        valid;
	logic                        ready;
	logic [hsvc_pkg::CLASS_W-1:0] color_class;
	logic                        not_found;

	modport source (output valid, color_class, not_found, input ready);
	modport sink   (input valid, color_class, not_found, output ready);
endinterface

// register write channel
interface hsvc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [hsvc_pkg::CFG_IDX_W-1:0] index;
	logic [hsvc_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/hsvc_cfg_regs.sv
// ----------------------------------------------------------------------------
// hsvc_cfg_regs
// configuration register bank: thresholds, hue bounds and hue enables
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsvc_cfg_regs #(
	parameter int unsigned HUE_ENTRIES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	hsvc_cfg_if.sink                      cfg,
	output hsvc_pkg::thresholds_t         thr,
	output logic [HUE_ENTRIES*hsvc_pkg::PIX_W-1:0] hue_bounds,
	output logic [HUE_ENTRIES-1:0]        hue_enables
);

	localparam int unsigned BOUNDS_W = HUE_ENTRIES * hsvc_pkg::PIX_W;

	hsvc_pkg::thresholds_t thr_q;
	logic [BOUNDS_W-1:0]    bounds_q;
	logic [HUE_ENTRIES-1:0] enables_q;

	// writes are taken in any cycle
	assign cfg.ready = 1'b1;

	// register write decode, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.black_value_max <= hsvc_pkg::RST_BLACK_VALUE_MAX;
			thr_q.white_value_min <= hsvc_pkg::RST_WHITE_VALUE_MIN;
			thr_q.white_sat_max   <= hsvc_pkg::RST_WHITE_SAT_MAX;
			thr_q.grey_sat_max    <= hsvc_pkg::RST_GREY_SAT_MAX;
			thr_q.grey_value_max  <= hsvc_pkg::RST_GREY_VALUE_MAX;
			bounds_q              <= '0;
			enables_q             <= '1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				hsvc_pkg::REG_BLACK_VALUE_MAX: begin
					thr_q.black_value_max <= cfg.data[hsvc_pkg::PIX_W-1:0];
				end
				hsvc_pkg::REG_WHITE_VALUE_MIN: begin
					thr_q.white_value_min <= cfg.data[hsvc_pkg::PIX_W-1:0];
				end
				hsvc_pkg::REG_WHITE_SAT_MAX: begin
					thr_q.white_sat_max <= cfg.data[hsvc_pkg::PIX_W-1:0];
				end
				hsvc_pkg::REG_GREY_SAT_MAX: begin
					thr_q.grey_sat_max <= cfg.data[hsvc_pkg::PIX_W-1:0];
				end
				hsvc_pkg::REG_GREY_VALUE_MAX: begin
					thr_q.grey_value_max <= cfg.data[hsvc_pkg::PIX_W-1:0];
				end
				hsvc_pkg::REG_HUE_BOUNDS: begin
					bounds_q <= cfg.data[BOUNDS_W-1:0];
				end
				hsvc_pkg::REG_HUE_ENABLES: begin
					enables_q <= cfg.data[HUE_ENTRIES-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign thr         = thr_q;
	assign hue_bounds  = bounds_q;
	assign hue_enables = enables_q;

endmodule

### rtl/core/hsvc_classify.sv
// ----------------------------------------------------------------------------
// hsvc_classify
// combinational colour decision for one pixel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsvc_classify #(
	parameter int unsigned HUE_ENTRIES = 8
) (
	input  hsvc_pkg::pixel_t      pix,
	input  hsvc_pkg::thresholds_t thr,
	input  logic [HUE_ENTRIES*hsvc_pkg::PIX_W-1:0] hue_bounds,
	input  logic [HUE_ENTRIES-1:0] hue_enables,
	output hsvc_pkg::result_t     res
);

	logic                          is_black;
	logic                          is_white;
	logic                          is_grey;
	logic [HUE_ENTRIES-1:0]        hue_match;
	logic [hsvc_pkg::CLASS_W-1:0]  hue_class;

	// achromatic tests
	assign is_black = pix.brightness < thr.black_value_max;
	assign is_white = (pix.brightness > thr.white_value_min) &&
		(pix.saturation < thr.white_sat_max);
	assign is_grey  = (pix.saturation < thr.grey_sat_max) &&
		(pix.brightness < thr.grey_value_max);

	// per entry bound compare
	always_comb begin
		for (int e = 0; e < HUE_ENTRIES; e++) begin
			hue_match[e] = hue_enables[e] &&
				(pix.hue <= hue_bounds[e*hsvc_pkg::PIX_W +: hsvc_pkg::PIX_W]);
		end
	end

	// lowest matching entry wins
	always_comb begin
		hue_class = hsvc_pkg::CLASS_BLACK;
		for (int e = HUE_ENTRIES - 1; e >= 0; e--) begin
			if (hue_match[e]) begin
				hue_class = hsvc_pkg::CLASS_HUE_BASE + hsvc_pkg::CLASS_W'(e);
			end
		end
	end

	// priority: black, white, grey, hue
	always_comb begin
		res.not_found = 1'b0;
		if (is_black) begin
			res.color_class = hsvc_pkg::CLASS_BLACK;
		end else if (is_white) begin
			res.color_class = hsvc_pkg::CLASS_WHITE;
		end else if (is_grey) begin
			res.color_class = hsvc_pkg::CLASS_GREY;
		end else if (|hue_match) begin
			res.color_class = hue_class;
		end else begin
			res.color_class = hsvc_pkg::CLASS_BLACK;
			res.not_found   = 1'b1;
		end
	end

endmodule

### rtl/core/hsv_pixel_color_classifier_core.sv
// ----------------------------------------------------------------------------
// hsv_pixel_color_classifier_core
// classifies one hsv pixel per item into black, white, grey or a hue class
// ----------------------------------------------------------------------------
//  channel | role   | payload
//  pix     | sink   | hue, saturation, brightness
//  res     | source | color_class, not_found
//  cfg     | sink   | index, data (register write)
//
//  one item per cycle sustained while res is ready; the path runs through the input
//  register, then classifier logic into the result register
//  reset clears both stage valids and loads the configuration registers with their defaults
//  a held result stalls the input register only once it is full as well
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hsv_pixel_color_classifier_core_assert.svh"

module hsv_pixel_color_classifier_core #(
	parameter int unsigned HUE_ENTRIES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	hsvc_pix_if.sink   pix,
	hsvc_res_if.source res,
	hsvc_cfg_if.sink   cfg
);

	hsvc_pkg::thresholds_t                  thr;
	logic [HUE_ENTRIES*hsvc_pkg::PIX_W-1:0] hue_bounds;
	logic [HUE_ENTRIES-1:0]                 hue_enables;

	logic               v_s1;
	hsvc_pkg::pixel_t   pix_s1;
	logic               v_s2;
	hsvc_pkg::result_t  res_s2;
	hsvc_pkg::result_t  res_next;
	logic               adv_s1;
	logic               adv_s2;

	// register bank
	hsvc_cfg_regs #(
		.HUE_ENTRIES(HUE_ENTRIES)
	) u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.thr        (thr),
		.hue_bounds (hue_bounds),
		.hue_enables(hue_enables)
	);

	// stage advance
	assign adv_s2    = !v_s2 || res.ready;
	assign adv_s1    = !v_s1 || adv_s2;
	assign pix.ready = adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pix.valid) begin
			pix_s1.hue        <= pix.hue;
			pix_s1.saturation <= pix.saturation;
			pix_s1.brightness <= pix.brightness;
		end
	end

	// classifier
	hsvc_classify #(
		.HUE_ENTRIES(HUE_ENTRIES)
	) u_classify (
		.pix        (pix_s1),
		.thr        (thr),
		.hue_bounds (hue_bounds),
		.hue_enables(hue_enables),
		.res        (res_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			res_s2 <= res_next;
		end
	end

	assign res.valid       = v_s2;
	assign res.color_class = res_s2.color_class;
	assign res.not_found   = res_s2.not_found;

	// checks
	`HSVC_ASSERT_NOW(a_miss_is_black, clk, arst_n, v_s2 && res_s2.not_found,
		res_s2.color_class == hsvc_pkg::CLASS_BLACK, "missed hue entry must report class zero")

	`HSVC_ASSERT_NOW(a_hue_class_range, clk, arst_n,
		v_s2 && (res_s2.color_class > hsvc_pkg::CLASS_GREY),
		res_s2.color_class < (hsvc_pkg::CLASS_HUE_BASE + hsvc_pkg::CLASS_W'(HUE_ENTRIES)),
		"hue class beyond entries")

	`HSVC_ASSERT_NEXT(a_s1_holds, clk, arst_n, v_s1 && !adv_s2,
		v_s1 && $stable(pix_s1), "stalled input register lost its item")

endmodule
